// ===== sv/ilb_pkg.sv =====
// ----------------------------------------------------------------------------
// ilb_pkg: shared types for the indexed ordered list buffer
// Command codes, sequencer states and the packed beat types of both channels.
// ----------------------------------------------------------------------------
package ilb_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_WRITE,
    ST_READ,
    ST_HEAD_RD,
    ST_TAIL_RD,
    ST_TAIL_CAP,
    ST_DONE
  } state_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [4:0]         position;
    logic signed [31:0] item_value;
  } in_beat_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] read_value;
    logic [4:0]         entry_count;
    logic signed [31:0] head_value;
    logic signed [31:0] tail_value;
  } out_beat_t;

endpackage

// ===== sv/ilb_ram.sv =====
// ----------------------------------------------------------------------------
// ilb_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ilb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/indexed_ordered_list_buffer.sv =====
// ----------------------------------------------------------------------------
// indexed_ordered_list_buffer: position-addressed ordered list of 32-bit values
// Inserts, deletes, overwrites or reads one entry per command and reports the
// count and the head and tail entries after the command.
// ----------------------------------------------------------------------------
//
//   channel  | ports                       | beat carries
//   ---------+-----------------------------+-------------------------------------
//   command  | in_valid, in_ready, in_data | cmd, position, item_value
//   result   | out_valid, out_ready,       | ok, read_value, entry_count,
//            | out_data                    | head_value, tail_value
//
// A read or overwrite passes its access state, then the head and tail fetch
// states, and the result beat is loaded in ST_DONE; a rejected command goes
// straight to ST_HEAD_RD, which leads on to ST_DONE on an empty list. An insert
// spends a shift read and a shift write on each entry moved, since the single
// RAM port pair moves one entry per read/write pair; an append moves nothing.
// A delete shifts each following entry down likewise; deleting the tail moves
// nothing, and the fetch is skipped when the list empties. in_ready rises
// together with the result beat, so the next command can be accepted as it appears.
// Reset clears the count, the sequencer and the result valid flag; the RAM
// needs no clearing because only positions below the count are ever read.
// A new command is taken as soon as the sequencer returns to idle, even while
// the previous result beat still waits for out_ready. If that beat is still
// waiting when the next result is ready, the sequencer holds until it is taken.
// ----------------------------------------------------------------------------
module indexed_ordered_list_buffer #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ilb_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ilb_pkg::out_beat_t out_data
);

  // Address width of the store, count width (must hold CAPACITY itself) and
  // a common width wide enough to compare a 5-bit position against the count.
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 5) ? CW : 5;

  ilb_pkg::state_t    state_r, state_nxt;
  ilb_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [31:0]        val_r, val_nxt;
  logic               ok_r, ok_nxt;
  logic [31:0]        rd_r, rd_nxt;
  logic [31:0]        head_r, head_nxt;
  logic [31:0]        tail_r, tail_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  ilb_pkg::out_beat_t out_data_r, out_data_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [31:0]        ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [31:0]        ram_rdata;

  logic [XW-1:0]      pos_x;
  logic [XW-1:0]      count_x;

  assign pos_x   = XW'(in_data.position);
  assign count_x = XW'(count_r);

  // The list lives in the RAM in order: list position p sits at address p.
  ilb_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ilb_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    ok_r       <= ok_nxt;
    rd_r       <= rd_nxt;
    head_r     <= head_nxt;
    tail_r     <= tail_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  // Sequencer. An insert walks from the tail down to the position, copying
  // each entry one address up, then writes the new value. A delete walks from
  // the position up, copying each following entry one address down. Every
  // command then fetches any head and tail before the result is loaded. The
  // result register is only loaded in the last state, so a beat that is still
  // waiting keeps its payload while the next command runs.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    ok_nxt        = ok_r;
    rd_nxt        = rd_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & ~out_ready;

    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = idx_r;

    case (state_r)
      ilb_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_data.cmd;
          pos_nxt = AW'(in_data.position);
          val_nxt = in_data.item_value;
          rd_nxt  = '0;
          ok_nxt  = 1'b0;
          if (in_data.cmd == ilb_pkg::CMD_INSERT) begin
            if ((pos_x <= count_x) && (count_x < XW'(CAPACITY))) begin
              ok_nxt = 1'b1;
              if (pos_x < count_x) begin
                idx_nxt   = AW'(count_r - CW'(1));
                state_nxt = ilb_pkg::ST_SHIFT_RD;
              end else begin
                state_nxt = ilb_pkg::ST_WRITE;
              end
            end else begin
              state_nxt = ilb_pkg::ST_HEAD_RD;
            end
          end else if (pos_x < count_x) begin
            ok_nxt = 1'b1;
            case (in_data.cmd)
              ilb_pkg::CMD_DELETE: begin
                idx_nxt = AW'(in_data.position);
                if (pos_x < count_x - XW'(1)) begin
                  state_nxt = ilb_pkg::ST_SHIFT_RD;
                end else begin
                  // Deleting the last entry moves nothing.
                  count_nxt = count_r - CW'(1);
                  state_nxt = ilb_pkg::ST_HEAD_RD;
                end
              end
              ilb_pkg::CMD_WRITE: begin
                state_nxt = ilb_pkg::ST_WRITE;
              end
              default: begin
                state_nxt = ilb_pkg::ST_READ;
              end
            endcase
          end else begin
            state_nxt = ilb_pkg::ST_HEAD_RD;
          end
        end
      end

      ilb_pkg::ST_SHIFT_RD: begin
        ram_re = 1'b1;
        if (cmd_r == ilb_pkg::CMD_INSERT) begin
          ram_raddr = idx_r;
        end else begin
          ram_raddr = idx_r + AW'(1);
        end
        state_nxt = ilb_pkg::ST_SHIFT_WR;
      end

      ilb_pkg::ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        if (cmd_r == ilb_pkg::CMD_INSERT) begin
          ram_waddr = idx_r + AW'(1);
          if (idx_r == pos_r) begin
            state_nxt = ilb_pkg::ST_WRITE;
          end else begin
            idx_nxt   = idx_r - AW'(1);
            state_nxt = ilb_pkg::ST_SHIFT_RD;
          end
        end else begin
          ram_waddr = idx_r;
          idx_nxt   = idx_r + AW'(1);
          if (CW'(idx_r) + CW'(1) == count_r - CW'(1)) begin
            count_nxt = count_r - CW'(1);
            state_nxt = ilb_pkg::ST_HEAD_RD;
          end else begin
            state_nxt = ilb_pkg::ST_SHIFT_RD;
          end
        end
      end

      ilb_pkg::ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = val_r;
        if (cmd_r == ilb_pkg::CMD_INSERT) begin
          count_nxt = count_r + CW'(1);
        end
        state_nxt = ilb_pkg::ST_HEAD_RD;
      end

      ilb_pkg::ST_READ: begin
        ram_re    = 1'b1;
        ram_raddr = pos_r;
        state_nxt = ilb_pkg::ST_HEAD_RD;
      end

      ilb_pkg::ST_HEAD_RD: begin
        // Read data here belongs to the read command, if that was the path.
        if ((cmd_r == ilb_pkg::CMD_READ) && ok_r) begin
          rd_nxt = ram_rdata;
        end
        if (count_r == '0) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          state_nxt = ilb_pkg::ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = '0;
          state_nxt = ilb_pkg::ST_TAIL_RD;
        end
      end

      ilb_pkg::ST_TAIL_RD: begin
        head_nxt  = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = AW'(count_r - CW'(1));
        state_nxt = ilb_pkg::ST_TAIL_CAP;
      end

      ilb_pkg::ST_TAIL_CAP: begin
        tail_nxt  = ram_rdata;
        state_nxt = ilb_pkg::ST_DONE;
      end

      ilb_pkg::ST_DONE: begin
        // The result register frees up once its beat has been taken.
        if (!out_valid_r || out_ready) begin
          out_data_nxt.ok          = ok_r;
          out_data_nxt.read_value  = rd_r;
          out_data_nxt.entry_count = 5'(count_x);
          out_data_nxt.head_value  = head_r;
          out_data_nxt.tail_value  = tail_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = ilb_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ilb_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == ilb_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The count can never pass the store size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // The count moves by at most one per cycle.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1))
             || (count_r == $past(count_r) - CW'(1)))
    else $error("entry count jumped");

  // Each shift write uses data fetched in the cycle before.
  a_shift_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ilb_pkg::ST_SHIFT_WR) |-> ($past(state_r) == ilb_pkg::ST_SHIFT_RD))
    else $error("shift write without preceding read");

  // A rejected command never touches the store.
  a_reject_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && (state_r != ilb_pkg::ST_IDLE)) |-> ok_r)
    else $error("store written by a rejected command");

endmodule

// ===== tb/tb_indexed_ordered_list_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_ordered_list_buffer: self-checking bench for the position-addressed list
// Sends insert, delete, overwrite and read commands. A shadow copy of the list
// forecasts each reply when its command beat is accepted, and every reply beat
// is checked field by field against the oldest forecast. Both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb_indexed_ordered_list_buffer;

  localparam int DEPTH = 16;

  // Shadow of the list contents. Every accepted command beat is applied here
  // in order, and the reply it should produce is queued until the block sends
  // the matching result beat.
  class list_mirror;
    logic signed [31:0] slots[DEPTH];
    int unsigned        fill;
    ilb_pkg::out_beat_t awaited_replies[$];
    int unsigned        errors;
    int unsigned        replies_seen;
    int unsigned        rejected;
    int unsigned        full_refusals;
    int unsigned        peak_fill;
    int unsigned        times_emptied;
    int unsigned        carried_out[4];

    function new();
      fill = 0;
      errors = 0;
      replies_seen = 0;
      rejected = 0;
      full_refusals = 0;
      peak_fill = 0;
      times_emptied = 0;
      foreach (carried_out[i]) carried_out[i] = 0;
    endfunction

    // Applies one accepted command and queues the reply it must produce.
    function void take_command(ilb_pkg::in_beat_t b);
      ilb_pkg::out_beat_t r;
      r = '0;
      if (b.cmd == ilb_pkg::CMD_INSERT) begin
        if (b.position <= fill && fill < DEPTH) begin
          for (int i = fill; i > b.position; i--) slots[i] = slots[i-1];
          slots[b.position] = b.item_value;
          fill++;
          r.ok = 1'b1;
        end else if (fill == DEPTH && b.position <= fill) begin
          full_refusals++;
        end
      end else if (b.position < fill) begin
        case (b.cmd)
          ilb_pkg::CMD_DELETE: begin
            for (int i = b.position; i < fill - 1; i++) slots[i] = slots[i+1];
            fill--;
            if (fill == 0) times_emptied++;
          end
          ilb_pkg::CMD_WRITE: slots[b.position] = b.item_value;
          default:            r.read_value = slots[b.position];
        endcase
        r.ok = 1'b1;
      end
      if (r.ok) carried_out[b.cmd]++;
      else rejected++;
      if (fill > peak_fill) peak_fill = fill;
      r.entry_count = fill[4:0];
      if (fill > 0) begin
        r.head_value = slots[0];
        r.tail_value = slots[fill-1];
      end
      awaited_replies.push_back(r);
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (got !== want) begin
        $error("reply %0d field %s: expected %0d, got %0d", replies_seen, name, want, got);
        errors++;
      end
    endfunction

    // Checks one accepted result beat against the oldest forecast.
    function void check_reply(ilb_pkg::out_beat_t got);
      ilb_pkg::out_beat_t want;
      if (awaited_replies.size() == 0) begin
        $error("result beat arrived with no command outstanding");
        errors++;
        return;
      end
      want = awaited_replies.pop_front();
      compare_field("ok", want.ok, got.ok);
      compare_field("read_value", want.read_value, got.read_value);
      compare_field("entry_count", want.entry_count, got.entry_count);
      compare_field("head_value", want.head_value, got.head_value);
      compare_field("tail_value", want.tail_value, got.tail_value);
      replies_seen++;
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  ilb_pkg::in_beat_t  in_data;
  logic               out_valid;
  logic               out_ready;
  ilb_pkg::out_beat_t out_data;

  list_mirror  mirror = new();
  bit          steady;          // when set, neither side idles
  int unsigned commands_sent;

  indexed_ordered_list_buffer #(
    .CAPACITY(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 4 ns clock period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Both handshakes are observed at the rising edge, where every bench-driven
  // input has been stable since the previous falling edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) mirror.take_command(in_data);
    if (rst_n && out_valid && out_ready) mirror.check_reply(out_data);
  end

  // The receiver stalls at random about 27 percent of the time, except during
  // the steady stretch.
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 27);
  end

  // Presents one command beat. The task is entered and left at a falling edge;
  // in_valid stays high on return so that a back-to-back beat never drops it.
  task automatic send_command(input ilb_pkg::cmd_t c, input logic [4:0] pos,
                              input logic signed [31:0] val);
    bit taken;
    taken = 1'b0;
    while (!steady && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_data.cmd        <= c;
    in_data.position   <= pos;
    in_data.item_value <= val;
    commands_sent++;
    while (!taken) begin
      @(posedge clk);
      taken = in_ready;
      @(negedge clk);
    end
  endtask

  // Holds the sender off until every forecast reply has been received.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (mirror.awaited_replies.size() != 0) @(negedge clk);
  endtask

  // Values lean toward the extremes of the signed range now and then.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(11))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      3:       return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  // Random commands with the given mix in percent; whatever is left of the
  // hundred goes to reads. Most positions are legal for the current length so
  // that the list actually grows, fills and drains; the rest probe just past
  // the end, the nominal range, and the whole 5-bit field.
  task automatic run_mix(input int count, input int ins_pct, input int del_pct,
                         input int wr_pct);
    int            roll;
    int            last_legal;
    ilb_pkg::cmd_t c;
    logic [4:0]    pos;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < ins_pct) c = ilb_pkg::CMD_INSERT;
      else if (roll < ins_pct + del_pct) c = ilb_pkg::CMD_DELETE;
      else if (roll < ins_pct + del_pct + wr_pct) c = ilb_pkg::CMD_WRITE;
      else c = ilb_pkg::CMD_READ;
      last_legal = (c == ilb_pkg::CMD_INSERT) ? int'(mirror.fill) : int'(mirror.fill) - 1;
      roll = $urandom_range(99);
      if (last_legal >= 0 && roll < 78) pos = 5'($urandom_range(last_legal, 0));
      else if (roll < 86) pos = 5'((last_legal + 1) & 31);
      else if (roll < 93) pos = 5'($urandom_range(DEPTH, 0));
      else pos = 5'($urandom_range(31, 0));
      send_command(c, pos, pick_value());
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    steady    = 1'b0;
    commands_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Every command on an empty list must be refused, and so
    // must an insert past the end.
    send_command(ilb_pkg::CMD_READ,   5'd0,  32'sd5);
    send_command(ilb_pkg::CMD_DELETE, 5'd0,  32'sd0);
    send_command(ilb_pkg::CMD_WRITE,  5'd0,  32'sd7);
    send_command(ilb_pkg::CMD_INSERT, 5'd1,  32'sd9);
    // Build a short list: first entry, append, prepend, then a middle insert.
    send_command(ilb_pkg::CMD_INSERT, 5'd0,  32'sh8000_0000);
    send_command(ilb_pkg::CMD_INSERT, 5'd1,  32'sh7fff_ffff);
    send_command(ilb_pkg::CMD_INSERT, 5'd0,  -32'sd1);
    send_command(ilb_pkg::CMD_INSERT, 5'd1,  32'sd0);
    // Read every entry, then one just past the end and one at the field limit.
    send_command(ilb_pkg::CMD_READ,   5'd0,  32'sd0);
    send_command(ilb_pkg::CMD_READ,   5'd1,  32'sd0);
    send_command(ilb_pkg::CMD_READ,   5'd2,  32'sd0);
    send_command(ilb_pkg::CMD_READ,   5'd3,  32'sd0);
    send_command(ilb_pkg::CMD_READ,   5'd4,  32'sd0);
    send_command(ilb_pkg::CMD_READ,   5'd31, 32'sd0);
    // Overwrite the tail in range and refuse one out of range.
    send_command(ilb_pkg::CMD_WRITE,  5'd3,  32'sh5a5a_a5a5);
    send_command(ilb_pkg::CMD_WRITE,  5'd16, 32'sd1);
    // Delete the tail, the head and the new tail, then the last remaining entry.
    send_command(ilb_pkg::CMD_DELETE, 5'd3,  32'sd0);
    send_command(ilb_pkg::CMD_DELETE, 5'd0,  32'sd0);
    send_command(ilb_pkg::CMD_DELETE, 5'd1,  32'sd0);
    send_command(ilb_pkg::CMD_DELETE, 5'd0,  32'sd0);
    send_command(ilb_pkg::CMD_READ,   5'd0,  32'sd0);
    send_command(ilb_pkg::CMD_INSERT, 5'd31, 32'sd3);
    wait_drained();

    // Insert-heavy mix: the list reaches capacity and inserts get refused.
    run_mix(150, 60, 15, 10);
    wait_drained();
    // Even mix, first with neither side idling, then with idling again.
    steady = 1'b1;
    run_mix(50, 25, 25, 25);
    steady = 1'b0;
    run_mix(50, 25, 25, 25);
    wait_drained();
    // Delete-heavy mix drains the list back to empty.
    run_mix(120, 15, 60, 10);
    wait_drained();
    run_mix(80, 45, 20, 15);
    wait_drained();
    repeat (16) @(negedge clk);

    if (mirror.awaited_replies.size() != 0) begin
      $error("%0d replies never arrived", mirror.awaited_replies.size());
      mirror.errors++;
    end
    $display("Sent %0d commands: %0d inserts, %0d deletes, %0d overwrites, %0d reads done,",
             commands_sent, mirror.carried_out[ilb_pkg::CMD_INSERT],
             mirror.carried_out[ilb_pkg::CMD_DELETE], mirror.carried_out[ilb_pkg::CMD_WRITE],
             mirror.carried_out[ilb_pkg::CMD_READ]);
    $display("%0d refused; list peaked at %0d of %0d, %0d full refusals, emptied %0d times.",
             mirror.rejected, mirror.peak_fill, DEPTH, mirror.full_refusals,
             mirror.times_emptied);
    if (mirror.errors == 0) begin
      $display("tb_indexed_ordered_list_buffer: clean");
    end else begin
      $display("tb_indexed_ordered_list_buffer: errors");
    end
    $finish;
  end

  // Watchdog: the slowest legal run needs well under a tenth of this.
  initial begin
    #2_000_000;
    $display("tb_indexed_ordered_list_buffer: errors");
    $finish;
  end

endmodule

// ===== files.f =====
sv/ilb_pkg.sv
sv/ilb_ram.sv
sv/indexed_ordered_list_buffer.sv
tb/tb_indexed_ordered_list_buffer.sv
